/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mfrs_pkg.sv */
// ----------------------------------------------------------------------------
// mfrs_pkg
// Constants, types and helper functions of the minmod face reconstruction.
// ----------------------------------------------------------------------------
package mfrs_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_WIDTH_W = 11;
    localparam int CMP_W       = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;
    localparam int DATA_W      = 32;
    localparam int DIFF_W      = DATA_W + 2;
    localparam int SUM_W       = DATA_W + 4;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;
    localparam logic [1:0]             ROWS_FULL       = 2'd2;

    localparam logic signed [SUM_W-1:0] Q_MAX = (SUM_W'(1) <<< (DATA_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] Q_MIN = -(SUM_W'(1) <<< (DATA_W - 1));

    typedef logic signed [DATA_W-1:0] sample_t;

    typedef struct packed {
        sample_t h_mid;
        sample_t z_mid;
        sample_t h_top;
        sample_t z_top;
    } line_word_t;

    // smaller magnitude when signs agree (zero counts as either), else zero
    function automatic logic signed [DIFF_W-1:0] minmod(
        input logic signed [DIFF_W-1:0] a,
        input logic signed [DIFF_W-1:0] b
    );
        logic signed [DIFF_W-1:0] res;
        res = '0;
        if (a >= 0 && b >= 0)
        begin
            res = (a <= b) ? a : b;
        end
        else if (a <= 0 && b <= 0)
        begin
            res = (a >= b) ? a : b;
        end
        return res;
    endfunction

endpackage

/* rtl/mfrs_ram.sv */
// ----------------------------------------------------------------------------
// mfrs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/minmod_face_reconstruct_stencil.sv */
// ----------------------------------------------------------------------------
// minmod_face_reconstruct_stencil
// Three-row minmod limited face reconstruction over a raster of h/z samples.
// ----------------------------------------------------------------------------
// Pipeline: the line store read is registered at item accept together with the
// sample (stage s1); the stencil is computed into the output register when s1
// moves, which face_stall can hold. Throughput: 1 item per cycle while no stall
// is held; one line store read and one write per item. Warm-up: the first two
// rows give no output item. Reset: counters and valids clear, row_width returns
// to 1024; the line stores are not cleared.
`include "assert_macros.svh"

module minmod_face_reconstruct_stencil (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mfrs_pkg::ROW_WIDTH_W-1:0]    cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [mfrs_pkg::DATA_W-1:0]  h_value,
    input  logic signed [mfrs_pkg::DATA_W-1:0]  z_value,
    output logic                                face_valid,
    input  logic                                face_stall,
    output logic signed [mfrs_pkg::DATA_W-1:0]  z_face,
    output logic                                row_end
);

    localparam int COL_W  = mfrs_pkg::COL_W;
    localparam int CMP_W  = mfrs_pkg::CMP_W;
    localparam int DIFF_W = mfrs_pkg::DIFF_W;
    localparam int SUM_W  = mfrs_pkg::SUM_W;
    localparam int DATA_W = mfrs_pkg::DATA_W;

    logic [mfrs_pkg::ROW_WIDTH_W-1:0] row_width_reg;
    logic [COL_W-1:0]                 col_reg, col_next;
    logic [1:0]                       rows_reg, rows_next;

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_emit_reg;
    logic                 s1_last_reg;
    logic [COL_W-1:0]     s1_col_reg;
    mfrs_pkg::sample_t    s1_h_reg, s1_z_reg;
    logic                 byp_sel_reg;
    mfrs_pkg::line_word_t byp_word_reg;

    logic                 face_valid_reg, face_valid_next;
    mfrs_pkg::sample_t    z_face_reg, z_face_next;
    logic                 row_end_reg;

    logic [CMP_W-1:0]     width_ext, width_eff;
    logic                 col_last;
    logic                 sample_accept;
    logic                 s1_move;
    logic                 bypass_hit;

    mfrs_pkg::line_word_t line_q, line_cur, wr_word;

    logic signed [DIFF_W-1:0] dh1, dz1, dh2, dz2, sum_1, sum_2, mm_a, mm_b;
    logic signed [SUM_W-1:0]  t_sum, r_half;

    // width handling
    always_comb
    begin
        width_ext = CMP_W'(row_width_reg);
        if (width_ext == '0)
        begin
            width_eff = CMP_W'(1);
        end
        else if (width_ext > CMP_W'(mfrs_pkg::MAX_WIDTH))
        begin
            width_eff = CMP_W'(mfrs_pkg::MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
    end

    assign col_last = (CMP_W'(col_reg) + CMP_W'(1)) >= width_eff;

    // handshake
    assign s1_move       = s1_valid_reg && (!s1_emit_reg || !face_valid_reg || !face_stall);
    assign sample_stall  = s1_valid_reg && !s1_move;
    assign sample_accept = sample_valid && !sample_stall;
    assign bypass_hit    = s1_move && (s1_col_reg == col_reg);

    always_comb
    begin
        col_next  = col_reg;
        rows_next = rows_reg;
        if (sample_accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                if (rows_reg != mfrs_pkg::ROWS_FULL)
                begin
                    rows_next = rows_reg + 2'd1;
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        if (sample_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_comb
    begin
        if (s1_move && s1_emit_reg)
        begin
            face_valid_next = 1'b1;
        end
        else if (!face_stall)
        begin
            face_valid_next = 1'b0;
        end
        else
        begin
            face_valid_next = face_valid_reg;
        end
    end

    // line store: {mid row, top row} per column
    mfrs_ram #(
        .WIDTH ($bits(mfrs_pkg::line_word_t)),
        .DEPTH (mfrs_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_col_reg),
        .wdata (wr_word),
        .re    (sample_accept),
        .raddr (col_reg),
        .rdata (line_q)
    );

    assign line_cur = byp_sel_reg ? byp_word_reg : line_q;

    always_comb
    begin
        wr_word.h_mid = s1_h_reg;
        wr_word.z_mid = s1_z_reg;
        wr_word.h_top = line_cur.h_mid;
        wr_word.z_top = line_cur.z_mid;
    end

    // stencil arithmetic
    always_comb
    begin
        dh1   = DIFF_W'(line_cur.h_mid) - DIFF_W'(s1_h_reg);
        dz1   = DIFF_W'(line_cur.z_mid) - DIFF_W'(s1_z_reg);
        dh2   = DIFF_W'(line_cur.h_top) - DIFF_W'(line_cur.h_mid);
        dz2   = DIFF_W'(line_cur.z_top) - DIFF_W'(line_cur.z_mid);
        sum_1 = dz1 + dh1;
        sum_2 = dz2 + dh2;
        mm_a  = mfrs_pkg::minmod(sum_1, sum_2);
        mm_b  = mfrs_pkg::minmod(dh1, dh2);
        t_sum = (SUM_W'(line_cur.z_mid) <<< 1) + SUM_W'(mm_a) - SUM_W'(mm_b)
                + SUM_W'(1);
        r_half = t_sum >>> 1;
        if (r_half > mfrs_pkg::Q_MAX)
        begin
            z_face_next = DATA_W'(mfrs_pkg::Q_MAX);
        end
        else if (r_half < mfrs_pkg::Q_MIN)
        begin
            z_face_next = DATA_W'(mfrs_pkg::Q_MIN);
        end
        else
        begin
            z_face_next = DATA_W'(r_half);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg  <= mfrs_pkg::ROW_WIDTH_RESET;
            col_reg        <= '0;
            rows_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            s1_emit_reg    <= 1'b0;
            face_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                row_width_reg <= cfg_data;
            end
            col_reg        <= col_next;
            rows_reg       <= rows_next;
            s1_valid_reg   <= s1_valid_next;
            face_valid_reg <= face_valid_next;
            if (sample_accept)
            begin
                s1_emit_reg <= (rows_reg == mfrs_pkg::ROWS_FULL);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            s1_last_reg  <= col_last;
            s1_col_reg   <= col_reg;
            s1_h_reg     <= h_value;
            s1_z_reg     <= z_value;
            byp_sel_reg  <= bypass_hit;
            byp_word_reg <= wr_word;
        end
        if (s1_move && s1_emit_reg)
        begin
            z_face_reg  <= z_face_next;
            row_end_reg <= s1_last_reg;
        end
    end

    assign face_valid = face_valid_reg;
    assign z_face     = z_face_reg;
    assign row_end    = row_end_reg;

    // checks
    `ASSERT_IMPLY(a_face_after_warmup, clk, rst_n, face_valid_reg, rows_reg == mfrs_pkg::ROWS_FULL, "result item before two rows stored")
    `ASSERT_NEXT(a_emit_reaches_output, clk, rst_n, s1_move && s1_emit_reg, face_valid_reg, "emitted item lost")
    `ASSERT_IMPLY(a_rows_saturate, clk, rst_n, 1'b1, rows_reg <= mfrs_pkg::ROWS_FULL, "row count past saturation")

endmodule

/* test/mfrs_face_checker.sv */
// ----------------------------------------------------------------------------
// mfrs_face_checker
// Watches the sample, face and width channels of the stencil, keeps its own
// line stores and width, predicts each face item and compares it in order.
// ----------------------------------------------------------------------------
module mfrs_face_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mfrs_pkg::ROW_WIDTH_W-1:0]    cfg_data,
    input  logic                                sample_valid,
    input  logic                                sample_stall,
    input  logic signed [mfrs_pkg::DATA_W-1:0]  h_value,
    input  logic signed [mfrs_pkg::DATA_W-1:0]  z_value,
    input  logic                                face_valid,
    input  logic                                face_stall,
    input  logic signed [mfrs_pkg::DATA_W-1:0]  z_face,
    input  logic                                row_end,
    input  logic                                drain_done,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  items_seen,
    output int                                  faces_checked
);
    import mfrs_pkg::*;

    typedef logic signed [SUM_W-1:0] wide_t;

    typedef struct packed {
        sample_t z;
        logic    last;
    } face_t;

    sample_t h_top_row [MAX_WIDTH];
    sample_t h_mid_row [MAX_WIDTH];
    sample_t z_top_row [MAX_WIDTH];
    sample_t z_mid_row [MAX_WIDTH];

    face_t                  expected_faces [$];
    face_t                  want;
    logic [ROW_WIDTH_W-1:0] width_reg = ROW_WIDTH_RESET;
    int unsigned            col_pos   = 0;
    int unsigned            rows_done = 0;
    int unsigned            eff_w;
    int unsigned            col;
    logic                   last_col;
    int                     errors    = 0;
    int                     waiting   = 0;
    int                     items     = 0;
    int                     checked   = 0;

    assign fail_count    = errors;
    assign pending       = waiting;
    assign items_seen    = items;
    assign faces_checked = checked;

    task report_mismatch(input string msg);
        errors++;
        if (errors <= 100)
        begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    // zero when either slope is zero or the signs differ
    function automatic wide_t smaller_slope(input wide_t a, input wide_t b);
        if (a == '0 || b == '0 || a[SUM_W-1] != b[SUM_W-1])
        begin
            return '0;
        end
        if (a[SUM_W-1])
        begin
            return (a > b) ? a : b;
        end
        return (a < b) ? a : b;
    endfunction

    function automatic face_t reconstruct_face(
        input sample_t ht, input sample_t hc, input sample_t hb,
        input sample_t zt, input sample_t zc, input sample_t zb,
        input logic    last
    );
        wide_t dh1, dz1, dh2, dz2, t, r;
        face_t f;
        dh1 = wide_t'(hc) - wide_t'(hb);
        dz1 = wide_t'(zc) - wide_t'(zb);
        dh2 = wide_t'(ht) - wide_t'(hc);
        dz2 = wide_t'(zt) - wide_t'(zc);
        t = (wide_t'(zc) <<< 1) + smaller_slope(dz1 + dh1, dz2 + dh2)
            - smaller_slope(dh1, dh2);
        // halve, ties toward plus infinity
        r = (t + wide_t'(1)) >>> 1;
        if (r > Q_MAX)
        begin
            r = Q_MAX;
        end
        else if (r < Q_MIN)
        begin
            r = Q_MIN;
        end
        f.z    = sample_t'(r);
        f.last = last;
        return f;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            width_reg = ROW_WIDTH_RESET;
            col_pos   = 0;
            rows_done = 0;
            expected_faces.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                width_reg = cfg_data;
            end

            if (face_valid && !face_stall)
            begin
                if (expected_faces.size() == 0)
                begin
                    report_mismatch($sformatf("face item with none expected: z_face=%h",
                        z_face));
                end
                else
                begin
                    want = expected_faces.pop_front();
                    if (z_face !== want.z)
                    begin
                        report_mismatch($sformatf("z_face %h, expected %h", z_face, want.z));
                    end
                    if (row_end !== want.last)
                    begin
                        report_mismatch($sformatf("row_end %b, expected %b (z_face %h)",
                            row_end, want.last, want.z));
                    end
                    checked++;
                end
            end

            if (sample_valid && !sample_stall)
            begin
                if (width_reg == 0)
                begin
                    eff_w = 1;
                end
                else if (width_reg > MAX_WIDTH)
                begin
                    eff_w = MAX_WIDTH;
                end
                else
                begin
                    eff_w = width_reg;
                end
                col      = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
                last_col = (col + 1 >= eff_w);

                if (rows_done >= 2)
                begin
                    expected_faces.push_back(reconstruct_face(
                        h_top_row[col], h_mid_row[col], h_value,
                        z_top_row[col], z_mid_row[col], z_value, last_col));
                end

                h_top_row[col] = h_mid_row[col];
                z_top_row[col] = z_mid_row[col];
                h_mid_row[col] = h_value;
                z_mid_row[col] = z_value;

                if (last_col)
                begin
                    col_pos = 0;
                    if (rows_done < 2)
                    begin
                        rows_done++;
                    end
                end
                else
                begin
                    col_pos = col + 1;
                end
                items++;
            end
        end
        waiting = expected_faces.size();
    end

    always @(posedge drain_done)
    begin
        if (expected_faces.size() != 0)
        begin
            report_mismatch($sformatf("%0d face items never arrived", expected_faces.size()));
        end
    end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for minmod_face_reconstruct_stencil: fills the line
// stores, drives directed corner stencils and random rasters over many row
// widths and idle mixes; the face checker predicts and compares every item.
// ----------------------------------------------------------------------------
module tb_top;
    import mfrs_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int TIMEOUT_CYCLES   = 400000;
    localparam int DIRECTED_COLS    = 24;
    localparam int STORE_COLS       = 32;
    localparam int RESET_WIDTH_COLS = 8;
    localparam int RANDOM_ITEMS     = 330;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [ROW_WIDTH_W-1:0] cfg_data;
    logic                   sample_valid;
    logic                   sample_stall;
    sample_t                h_value;
    sample_t                z_value;
    logic                   face_valid;
    logic                   face_stall;
    sample_t                z_face;
    logic                   row_end;
    logic                   drain_done;

    int fail_count;
    int pending;
    int items_seen;
    int faces_checked;

    int src_pct  = 0;
    int sink_pct = 0;
    int widths_written = 0;

    minmod_face_reconstruct_stencil dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .h_value      (h_value),
        .z_value      (z_value),
        .face_valid   (face_valid),
        .face_stall   (face_stall),
        .z_face       (z_face),
        .row_end      (row_end)
    );

    mfrs_face_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .h_value       (h_value),
        .z_value       (z_value),
        .face_valid    (face_valid),
        .face_stall    (face_stall),
        .z_face        (z_face),
        .row_end       (row_end),
        .drain_done    (drain_done),
        .fail_count    (fail_count),
        .pending       (pending),
        .items_seen    (items_seen),
        .faces_checked (faces_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

    always @(negedge clk)
    begin
        face_stall <= ($urandom_range(0, 99) < sink_pct);
    end

    function automatic sample_t corner_value(input int k);
        case (k % 8)
            0: return sample_t'(32'h8000_0000);
            1: return sample_t'(32'h7FFF_FFFF);
            2: return sample_t'(32'h0000_0000);
            3: return sample_t'(32'h0000_0001);
            4: return sample_t'(32'hFFFF_FFFF);
            5: return sample_t'(32'h0001_0000);
            6: return sample_t'(32'hFFFF_0000);
            default: return sample_t'(32'h4000_0000);
        endcase
    endfunction

    function automatic sample_t random_sample();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k == 0)
        begin
            return corner_value($urandom_range(0, 7));
        end
        if (k < 5)
        begin
            return sample_t'(int'($urandom_range(0, 32'h80000)) - 32'sh40000);
        end
        return sample_t'($urandom);
    endfunction

    task set_mix(input int m);
        case (m % 4)
            0: begin src_pct = 0;  sink_pct = 0;  end
            1: begin src_pct = 66; sink_pct = 0;  end
            2: begin src_pct = 0;  sink_pct = 66; end
            default: begin src_pct = 35; sink_pct = 35; end
        endcase
    endtask

    // entered and left at a falling edge
    task send_item(input sample_t h, input sample_t z);
        while ($urandom_range(0, 99) < src_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        h_value      <= h;
        z_value      <= z;
        @(posedge clk);
        while (sample_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // all expected faces delivered, then pipeline drained
    task settle();
        sample_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task write_width(input int v);
        cfg_we   <= 1'b1;
        cfg_data <= ROW_WIDTH_W'(v);
        @(negedge clk);
        cfg_we   <= 1'b0;
        widths_written++;
    endtask

    initial
    begin
        sample_t col_h [3];
        sample_t col_z [3];
        int      r;
        int      c;
        int      n;
        int      pick;
        int      phase;
        int      rand_items;
        int      guard;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        sample_valid = 1'b0;
        h_value      = '0;
        z_value      = '0;
        drain_done   = 1'b0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // first columns at reset width, then a narrow store for two rows,
        // then corner stencils on the third
        set_mix(0);
        for (r = 0; r < 3; r++)
        begin
            for (c = 0; c < ((r < 2) ? STORE_COLS : DIRECTED_COLS); c++)
            begin
                if (r == 0 && c == RESET_WIDTH_COLS)
                begin
                    settle();
                    write_width(STORE_COLS);
                end
                if (c >= DIRECTED_COLS)
                begin
                    send_item(random_sample(), random_sample());
                end
                else
                begin
                    // index 0 top, 1 centre, 2 bottom
                    col_h = '{sample_t'(0), sample_t'(0), sample_t'(0)};
                    col_z = '{sample_t'(0), sample_t'(0), sample_t'(0)};
                    case (c)
                        0: ;
                        1:
                        begin
                            // positive saturation
                            col_h = '{sample_t'(32'h4000_0000), sample_t'(0),
                                      sample_t'(32'h4000_0000)};
                            col_z = '{corner_value(1), corner_value(1), corner_value(0)};
                        end
                        2:
                        begin
                            // negative saturation
                            col_h = '{sample_t'(32'hC000_0000), sample_t'(0),
                                      sample_t'(32'hC000_0000)};
                            col_z = '{corner_value(0), corner_value(0), corner_value(1)};
                        end
                        3: col_z = '{sample_t'(1), sample_t'(0), sample_t'(-1)};
                        4: col_z = '{sample_t'(-1), sample_t'(0), sample_t'(1)};
                        5: col_z = '{sample_t'(5), sample_t'(0), sample_t'(5)};
                        6:
                        begin
                            col_h = '{sample_t'(32'h1_0000), sample_t'(32'h8000),
                                      sample_t'(0)};
                            col_z = '{sample_t'(3), sample_t'(0), sample_t'(0)};
                        end
                        7:
                        begin
                            col_h = '{corner_value(1), corner_value(1), corner_value(1)};
                            col_z = '{corner_value(1), corner_value(1), corner_value(1)};
                        end
                        8:
                        begin
                            col_h = '{corner_value(0), corner_value(0), corner_value(0)};
                            col_z = '{corner_value(0), corner_value(0), corner_value(0)};
                        end
                        default:
                        begin
                            for (n = 0; n < 3; n++)
                            begin
                                col_h[n] = corner_value(c + 3 * n);
                                col_z[n] = corner_value(5 * c + 2 * n);
                            end
                        end
                    endcase
                    send_item(col_h[r], col_z[r]);
                end
            end
        end
        settle();

        // above the store size on a partial row, stays inside filled columns
        write_width(2047);
        set_mix(1);
        for (c = 0; c < STORE_COLS - DIRECTED_COLS - 1; c++)
        begin
            send_item(random_sample(), random_sample());
        end
        settle();

        // zero width mid-row, then one
        write_width(0);
        set_mix(2);
        for (c = 0; c < 15; c++)
        begin
            send_item(random_sample(), random_sample());
        end
        settle();
        write_width(1);
        set_mix(3);
        for (c = 0; c < 15; c++)
        begin
            send_item(random_sample(), random_sample());
        end
        settle();

        rand_items = 0;
        phase      = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            set_mix(phase);
            if (pick == 2 || pick == 3)
            begin
                // close the row so a wide row starts at column 0
                write_width(1);
                send_item(random_sample(), random_sample());
                rand_items++;
                settle();
            end
            case (pick)
                0: write_width(0);
                1: write_width(1);
                2: write_width(2047);
                3: write_width($urandom_range(MAX_WIDTH + 1, 2046));
                default: write_width($urandom_range(2, STORE_COLS));
            endcase
            n = $urandom_range(8, STORE_COLS - 1);
            for (c = 0; c < n; c++)
            begin
                if (c == n / 2 && (phase == 0 || $urandom_range(0, 3) == 0))
                begin
                    settle();
                end
                send_item(random_sample(), random_sample());
                rand_items++;
            end
            settle();
            phase++;
        end

        sample_valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);
        drain_done <= 1'b1;
        @(negedge clk);

        $display("Run: %0d sample items in, %0d face items checked, %0d width writes",
            items_seen, faces_checked, widths_written);
        $display("Widths 0, 1, 2..32, reset width and above 1024 on partial rows, %s",
            "mid-row changes, four idle mixes");
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/mfrs_pkg.sv
rtl/mfrs_ram.sv
rtl/minmod_face_reconstruct_stencil.sv
test/mfrs_face_checker.sv
test/tb_top.sv
